// ===== rtl/tsfm_pkg.sv =====
// Shared types and constants for the touch sample filter and mapper.
// Used by every file in rtl; depends on nothing.
package tsfm_pkg;

  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned SAMPLE_W = 13;
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned SCALE_W  = 18;
  localparam int unsigned SHIFT_W  = 16;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAME_DROP = 3;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned RECIP_W  = 19;

  localparam logic [SAMPLE_W-1:0] SAMPLE_ONES = '1;

  // Burst order within one measurement.
  localparam logic [1:0] BURST_X1 = 2'd0;
  localparam logic [1:0] BURST_Y1 = 2'd1;
  localparam logic [1:0] BURST_X2 = 2'd2;
  localparam logic [1:0] BURST_Y2 = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SHIFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SHIFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_HIGH = 3'd7;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNSTABLE  = 2'd1,
    ST_WINDOW    = 2'd2,
    ST_OFFSCREEN = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] x_scale;
    logic signed [SCALE_W-1:0] y_scale;
    logic signed [SHIFT_W-1:0] x_shift;
    logic signed [SHIFT_W-1:0] y_shift;
    logic [SAMPLE_W-1:0]       raw_x_low;
    logic [SAMPLE_W-1:0]       raw_x_high;
    logic [SAMPLE_W-1:0]       raw_y_low;
    logic [SAMPLE_W-1:0]       raw_y_high;
  } cfg_t;

  // One finished burst, handed from the front to the back.
  typedef struct packed {
    logic [1:0]          burst;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] max;
    logic [SAMPLE_W-1:0] min;
  } burst_t;

endpackage

// ===== rtl/tsfm_if.sv =====
// Valid/ready channel interfaces for frames in and mapped points out.
// Depends on tsfm_pkg for field widths.
interface tsfm_frame_if;
  logic                          valid;
  logic                          ready;
  logic [tsfm_pkg::FRAME_W-1:0]  frame;
  logic                          restart;
  modport source (output valid, output frame, output restart, input ready);
  modport sink   (input valid, input frame, input restart, output ready);
endinterface

interface tsfm_point_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [tsfm_pkg::PIX_W-1:0]     column;
  logic [tsfm_pkg::PIX_W-1:0]     row;
  logic [tsfm_pkg::SAMPLE_W-1:0]  raw_x;
  logic [tsfm_pkg::SAMPLE_W-1:0]  raw_y;
  modport source (output valid, output status, output column, output row,
                  output raw_x, output raw_y, input ready);
  modport sink   (input valid, input status, input column, input row,
                  input raw_x, input raw_y, output ready);
endinterface

// ===== rtl/tsfm_front.sv =====
// Front end: takes frames, keeps running sum/max/min per burst and pushes
// one burst summary to the queue at the end of each burst. Uses tsfm_pkg.
module tsfm_front #(
  parameter int unsigned SAMPLES_PER_BURST = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  tsfm_frame_if.sink            samples,
  input  logic                  push_ready,
  output logic                  push_valid,
  output tsfm_pkg::burst_t      push_data
);

  localparam int unsigned IDX_W = $clog2(SAMPLES_PER_BURST);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_BURST - 1);

  logic [IDX_W-1:0]              sample_index;
  logic [1:0]                    burst_index;
  logic [tsfm_pkg::SUM_W-1:0]    running_sum;
  logic [tsfm_pkg::SAMPLE_W-1:0] running_max;
  logic [tsfm_pkg::SAMPLE_W-1:0] running_min;

  logic [IDX_W-1:0]              base_idx;
  logic [1:0]                    base_burst;
  logic [tsfm_pkg::SUM_W-1:0]    base_sum;
  logic [tsfm_pkg::SAMPLE_W-1:0] base_max;
  logic [tsfm_pkg::SAMPLE_W-1:0] base_min;
  logic [tsfm_pkg::SAMPLE_W-1:0] sample;
  logic [tsfm_pkg::SUM_W-1:0]    sum_next;
  logic [tsfm_pkg::SAMPLE_W-1:0] max_next;
  logic [tsfm_pkg::SAMPLE_W-1:0] min_next;
  logic                          last;
  logic                          take;

  assign samples.ready = push_ready;
  assign take = samples.valid && samples.ready;
  assign sample = samples.frame[tsfm_pkg::FRAME_W-1:tsfm_pkg::FRAME_DROP];

  // Restart drops the partial measurement before this frame counts.
  always_comb begin
    if (samples.restart) begin
      base_idx   = '0;
      base_burst = tsfm_pkg::BURST_X1;
      base_sum   = '0;
      base_max   = '0;
      base_min   = tsfm_pkg::SAMPLE_ONES;
    end else begin
      base_idx   = sample_index;
      base_burst = burst_index;
      base_sum   = running_sum;
      base_max   = running_max;
      base_min   = running_min;
    end
    sum_next = base_sum + tsfm_pkg::SUM_W'(sample);
    max_next = (sample > base_max) ? sample : base_max;
    min_next = (sample < base_min) ? sample : base_min;
    last     = (base_idx == IDX_LAST);
  end

  assign push_valid      = take && last;
  assign push_data.burst = base_burst;
  assign push_data.sum   = sum_next;
  assign push_data.max   = max_next;
  assign push_data.min   = min_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      burst_index  <= tsfm_pkg::BURST_X1;
      running_sum  <= '0;
      running_max  <= '0;
      running_min  <= tsfm_pkg::SAMPLE_ONES;
    end else if (take) begin
      if (last) begin
        sample_index <= '0;
        burst_index  <= base_burst + 2'd1;
        running_sum  <= '0;
        running_max  <= '0;
        running_min  <= tsfm_pkg::SAMPLE_ONES;
      end else begin
        sample_index <= base_idx + IDX_W'(1);
        burst_index  <= base_burst;
        running_sum  <= sum_next;
        running_max  <= max_next;
        running_min  <= min_next;
      end
    end
  end

endmodule

// ===== rtl/tsfm_fifo.sv =====
// Two-entry queue of burst summaries between front and back.
// Uses tsfm_pkg::burst_t.
module tsfm_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  tsfm_pkg::burst_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tsfm_pkg::burst_t  pop_data
);

  tsfm_pkg::burst_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2 && wr_ptr == $past(wr_ptr)))
    else $error("queue written while full");
`endif

endmodule

// ===== rtl/tsfm_back.sv =====
// Back end: trimmed mean per burst, pair checks, window test and pixel
// mapping, ending in the output register. Uses tsfm_pkg and tsfm_if.
module tsfm_back #(
  parameter int unsigned SAMPLES_PER_BURST = 5,
  parameter int unsigned SPREAD_LIMIT      = 50,
  parameter int unsigned SCREEN_COLUMNS    = 128,
  parameter int unsigned SCREEN_ROWS       = 160
) (
  input  logic              clk,
  input  logic              rst,
  input  tsfm_pkg::cfg_t    cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  tsfm_pkg::burst_t  pop_data,
  tsfm_point_if.source      points
);

  localparam int unsigned SUM_W  = tsfm_pkg::SUM_W;
  localparam int unsigned SMP_W  = tsfm_pkg::SAMPLE_W;
  localparam int unsigned PROD_W = SUM_W + tsfm_pkg::RECIP_W;
  localparam int unsigned MUL_W  = SMP_W + 1 + tsfm_pkg::SCALE_W;
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(SAMPLES_PER_BURST - 2);
  // floor(2^18 / divisor): quotient from the product is exact or one short.
  localparam logic [tsfm_pkg::RECIP_W-1:0] RECIP =
    tsfm_pkg::RECIP_W'((1 << tsfm_pkg::RECIP_SHIFT) / (SAMPLES_PER_BURST - 2));
  localparam logic [SMP_W:0]          LIMIT   = (SMP_W + 1)'(SPREAD_LIMIT);
  localparam logic [tsfm_pkg::PIX_W-1:0] MAX_COL = tsfm_pkg::PIX_W'(SCREEN_COLUMNS);
  localparam logic [tsfm_pkg::PIX_W-1:0] MAX_ROW = tsfm_pkg::PIX_W'(SCREEN_ROWS);

  logic adv;

  // Stage A: trimmed sum and reciprocal product.
  logic              a_valid;
  logic [1:0]        a_burst;
  logic [SUM_W-1:0]  a_trim;
  logic [PROD_W-1:0] a_prod;
  logic [SUM_W-1:0]  trim;
  logic [SUM_W-1:0]  ends;

  // Stage B: burst mean.
  logic             b_valid;
  logic [1:0]       b_burst;
  logic [SMP_W-1:0] b_mean;
  logic [SUM_W-1:0] q0;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] quot;

  // Stage C: pair checks and window.
  logic [SMP_W-1:0]  burst_means [3];
  logic              c_valid;
  tsfm_pkg::status_t c_status;
  logic [SMP_W-1:0]  c_ax;
  logic [SMP_W-1:0]  c_ay;
  logic [SMP_W:0]    dx;
  logic [SMP_W:0]    dy;
  logic [SMP_W:0]    sx;
  logic [SMP_W:0]    sy;
  logic [SMP_W-1:0]  ax;
  logic [SMP_W-1:0]  ay;
  logic              unstable;
  logic              outside;

  // Stage D: scaled products.
  logic              d_valid;
  tsfm_pkg::status_t d_status;
  logic [SMP_W-1:0]  d_ax;
  logic [SMP_W-1:0]  d_ay;
  logic signed [MUL_W-1:0] d_px;
  logic signed [MUL_W-1:0] d_py;

  // Output stage.
  logic [tsfm_pkg::PIX_W-1:0] col;
  logic [tsfm_pkg::PIX_W-1:0] row;

  assign adv       = !points.valid || points.ready;
  assign pop_ready = adv;

  always_comb begin
    ends = SUM_W'(pop_data.max) + SUM_W'(pop_data.min);
    trim = (pop_data.sum < ends) ? '0 : (pop_data.sum - ends);
  end

  always_comb begin
    q0   = a_prod[tsfm_pkg::RECIP_SHIFT +: SUM_W];
    rem  = a_trim - SUM_W'(q0 * DIVISOR);
    quot = (rem >= DIVISOR) ? (q0 + SUM_W'(1)) : q0;
  end

  always_comb begin
    dx = (burst_means[0] > burst_means[2]) ?
         ({1'b0, burst_means[0]} - {1'b0, burst_means[2]}) :
         ({1'b0, burst_means[2]} - {1'b0, burst_means[0]});
    dy = (burst_means[1] > b_mean) ?
         ({1'b0, burst_means[1]} - {1'b0, b_mean}) :
         ({1'b0, b_mean} - {1'b0, burst_means[1]});
    sx = {1'b0, burst_means[0]} + {1'b0, burst_means[2]};
    sy = {1'b0, burst_means[1]} + {1'b0, b_mean};
    ax = sx[SMP_W:1];
    ay = sy[SMP_W:1];
    unstable = (dx > LIMIT) || (dy > LIMIT);
    outside  = (ax < cfg.raw_x_low) || (ax > cfg.raw_x_high) ||
               (ay < cfg.raw_y_low) || (ay > cfg.raw_y_high);
  end

  // Truncate toward zero: a negative product with a fraction rounds up by one.
  always_comb begin
    col = d_px[23:16] + tsfm_pkg::PIX_W'(d_px[MUL_W-1] && (d_px[15:0] != '0))
        + cfg.x_shift[tsfm_pkg::PIX_W-1:0];
    row = d_py[23:16] + tsfm_pkg::PIX_W'(d_py[MUL_W-1] && (d_py[15:0] != '0))
        + cfg.y_shift[tsfm_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_burst <= pop_data.burst;
      a_trim  <= trim;
      a_prod  <= PROD_W'(trim) * PROD_W'(RECIP);
      b_burst <= a_burst;
      b_mean  <= quot[SMP_W-1:0];
      c_ax    <= ax;
      c_ay    <= ay;
      if (unstable) begin
        c_status <= tsfm_pkg::ST_UNSTABLE;
      end else if (outside) begin
        c_status <= tsfm_pkg::ST_WINDOW;
      end else begin
        c_status <= tsfm_pkg::ST_OK;
      end
      if (b_valid && b_burst != tsfm_pkg::BURST_Y2) begin
        burst_means[b_burst] <= b_mean;
      end
      d_status <= c_status;
      d_ax     <= c_ax;
      d_ay     <= c_ay;
      d_px     <= MUL_W'($signed({1'b0, c_ax})) * MUL_W'(cfg.x_scale);
      d_py     <= MUL_W'($signed({1'b0, c_ay})) * MUL_W'(cfg.y_scale);
      case (d_status)
        tsfm_pkg::ST_UNSTABLE: begin
          points.status <= tsfm_pkg::ST_UNSTABLE;
          points.column <= '0;
          points.row    <= '0;
          points.raw_x  <= '0;
          points.raw_y  <= '0;
        end
        tsfm_pkg::ST_WINDOW: begin
          points.status <= tsfm_pkg::ST_WINDOW;
          points.column <= '0;
          points.row    <= '0;
          points.raw_x  <= d_ax;
          points.raw_y  <= d_ay;
        end
        default: begin
          points.status <= ((col > MAX_COL) || (row > MAX_ROW)) ?
                           tsfm_pkg::ST_OFFSCREEN : tsfm_pkg::ST_OK;
          points.column <= col;
          points.row    <= row;
          points.raw_x  <= d_ax;
          points.raw_y  <= d_ay;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      d_valid      <= 1'b0;
      points.valid <= 1'b0;
    end else if (adv) begin
      a_valid      <= pop_valid;
      b_valid      <= a_valid;
      // Only the last burst of a measurement goes on to mapping.
      c_valid      <= b_valid && (b_burst == tsfm_pkg::BURST_Y2);
      d_valid      <= c_valid;
      points.valid <= d_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_unstable_zero: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.status == tsfm_pkg::ST_UNSTABLE) |->
    (points.column == '0 && points.row == '0 && points.raw_x == '0 &&
     points.raw_y == '0))
    else $error("unstable result carries nonzero fields");
  a_window_zero: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.status == tsfm_pkg::ST_WINDOW) |->
    (points.column == '0 && points.row == '0))
    else $error("window reject carries a pixel position");
  a_ok_on_screen: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.status == tsfm_pkg::ST_OK) |->
    (points.column <= MAX_COL && points.row <= MAX_ROW))
    else $error("ok result lies beyond the screen");
  a_offscreen: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.status == tsfm_pkg::ST_OFFSCREEN) |->
    (points.column > MAX_COL || points.row > MAX_ROW))
    else $error("off-screen result lies on the screen");
`endif

endmodule

// ===== rtl/touch_sample_filter_and_map.sv =====
// Top level of the touch sample filter and mapper: configuration registers,
// front end, burst queue and back end. Uses tsfm_pkg, tsfm_if and submodules.
//
//   port       dir   kind        payload
//   samples    in    valid/ready frame[15:0], restart
//   points     out   valid/ready status[1:0], column, row, raw_x, raw_y
//   cfg_*      in    write only  cfg_index[2:0], cfg_data[17:0]
//
// One frame is taken every cycle while the two-entry burst queue has room.
// A burst summary from the queue passes stages A to D and the output register;
// the divide takes two stages, the pair checks and the scale multiply one each.
// A stalled result holds the back pipeline; the queue lets the front keep
// taking frames for up to two more bursts. Reset is synchronous and clears
// counters, valid bits and the configuration to its reset values.
module touch_sample_filter_and_map #(
  parameter int unsigned SAMPLES_PER_BURST = 5,
  parameter int unsigned SPREAD_LIMIT      = 50,
  parameter int unsigned SCREEN_COLUMNS    = 128,
  parameter int unsigned SCREEN_ROWS       = 160
) (
  input  logic                              clk,
  input  logic                              rst,
  tsfm_frame_if.sink                        samples,
  tsfm_point_if.source                      points,
  input  logic                              cfg_write,
  input  logic [tsfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsfm_pkg::CFG_W-1:0]        cfg_data
);

  tsfm_pkg::cfg_t   cfg;
  logic             push_valid;
  logic             push_ready;
  tsfm_pkg::burst_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  tsfm_pkg::burst_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale    <= '0;
      cfg.y_scale    <= '0;
      cfg.x_shift    <= '0;
      cfg.y_shift    <= '0;
      cfg.raw_x_low  <= '0;
      cfg.raw_x_high <= tsfm_pkg::SAMPLE_ONES;
      cfg.raw_y_low  <= '0;
      cfg.raw_y_high <= tsfm_pkg::SAMPLE_ONES;
    end else if (cfg_write) begin
      case (cfg_index)
        tsfm_pkg::CFG_X_SCALE:    cfg.x_scale    <= cfg_data;
        tsfm_pkg::CFG_Y_SCALE:    cfg.y_scale    <= cfg_data;
        tsfm_pkg::CFG_X_SHIFT:    cfg.x_shift    <= cfg_data[tsfm_pkg::SHIFT_W-1:0];
        tsfm_pkg::CFG_Y_SHIFT:    cfg.y_shift    <= cfg_data[tsfm_pkg::SHIFT_W-1:0];
        tsfm_pkg::CFG_RAW_X_LOW:  cfg.raw_x_low  <= cfg_data[tsfm_pkg::SAMPLE_W-1:0];
        tsfm_pkg::CFG_RAW_X_HIGH: cfg.raw_x_high <= cfg_data[tsfm_pkg::SAMPLE_W-1:0];
        tsfm_pkg::CFG_RAW_Y_LOW:  cfg.raw_y_low  <= cfg_data[tsfm_pkg::SAMPLE_W-1:0];
        tsfm_pkg::CFG_RAW_Y_HIGH: cfg.raw_y_high <= cfg_data[tsfm_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  tsfm_front #(
    .SAMPLES_PER_BURST (SAMPLES_PER_BURST)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  tsfm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tsfm_back #(
    .SAMPLES_PER_BURST (SAMPLES_PER_BURST),
    .SPREAD_LIMIT      (SPREAD_LIMIT),
    .SCREEN_COLUMNS    (SCREEN_COLUMNS),
    .SCREEN_ROWS       (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .points    (points)
  );

endmodule
